// File: sv/fff_pkg.sv
package fff_pkg;

    localparam int FX_W      = 32;
    localparam int FX_FRAC   = 16;
    localparam int DIV_BITS  = FX_W + FX_FRAC;
    localparam int DIV_STEP  = 4;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

    localparam int GAMMA_W = 18;
    localparam int RATIO_W = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [GAMMA_W-1:0] HEAT_RATIO_RST = 18'd91750;
    localparam logic [RATIO_W-1:0] DT_OVER_DX_RST = 31'd32768;
    localparam logic [RATIO_W-1:0] DX_OVER_DT_RST = 31'd131072;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAT_RATIO = 2'd0,
        CFG_DT_OVER_DX = 2'd1,
        CFG_DX_OVER_DT = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    typedef logic signed [FX_W-1:0] t_fx;

    localparam t_fx FX_MAX = 32'sh7fffffff;
    localparam t_fx FX_MIN = 32'sh80000000;

    typedef struct packed {
        t_fx r;
        t_fx m;
        t_fx e;
    } t_cons;

    typedef struct packed {
        t_fx g;
        t_fx gm1;
        t_fx c3;
        t_fx c1;
    } t_coef;

    typedef struct packed {
        t_fx  v;
        logic s;
    } t_res;

    function automatic t_res fx_clamp(input logic signed [65:0] x);
        t_res r;
        r.s = 1'b0;
        if (x > 66'sd2147483647) begin
            r.v = FX_MAX;
            r.s = 1'b1;
        end else if (x < -66'sd2147483648) begin
            r.v = FX_MIN;
            r.s = 1'b1;
        end else begin
            r.v = x[31:0];
        end
        return r;
    endfunction

    function automatic t_res fx_mul(input t_fx a, input t_fx b);
        logic signed [63:0] p;
        logic signed [65:0] w;
        p = a * b;
        w = ($signed({{2{p[63]}}, p}) + 66'sd32768) >>> FX_FRAC;
        return fx_clamp(w);
    endfunction

    function automatic t_res fx_add(input t_fx a, input t_fx b);
        return fx_clamp($signed({{34{a[31]}}, a}) + $signed({{34{b[31]}}, b}));
    endfunction

    function automatic t_res fx_sub(input t_fx a, input t_fx b);
        return fx_clamp($signed({{34{a[31]}}, a}) - $signed({{34{b[31]}}, b}));
    endfunction

    // rounded half up average from the exact sum
    function automatic t_fx fx_avg(input t_fx a, input t_fx b);
        logic signed [33:0] s;
        logic signed [33:0] h;
        s = $signed({{2{a[31]}}, a}) + $signed({{2{b[31]}}, b}) + 34'sd1;
        h = s >>> 1;
        return h[31:0];
    endfunction

    function automatic t_coef make_coef(input logic [GAMMA_W-1:0] g);
        t_coef c;
        t_fx   t;
        c.g   = $signed({14'b0, g});
        c.gm1 = c.g - 32'sd65536;
        t     = 32'sd196608 - c.g + 32'sd1;
        c.c3  = t >>> 1;
        t     = c.gm1 + 32'sd1;
        c.c1  = t >>> 1;
        return c;
    endfunction

endpackage

// File: sv/fff_euler.sv
module fff_euler
    import fff_pkg::*;
#(
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_cons         i_q,
    input  logic          i_sat,
    input  logic [PW-1:0] i_payload,
    input  t_coef         i_coef,
    output logic          o_valid,
    output t_cons         o_q,
    output t_cons         o_flux,
    output logic          o_sat,
    output logic [PW-1:0] o_payload
);

    // entry, divide steps, divide result, four flux stages
    localparam int LAT = DIV_STAGES + 6;

    logic          r_vld [0:LAT-1];
    t_cons         r_q   [0:LAT-1];
    logic [PW-1:0] r_pay [0:LAT-1];
    logic          r_sat [0:DIV_STAGES];

    logic [DIV_BITS-1:0] r_num  [0:DIV_STAGES];
    logic [DIV_BITS-1:0] r_quo  [0:DIV_STAGES];
    logic [FX_W-1:0]     r_den  [0:DIV_STAGES];
    logic [FX_W-1:0]     r_rem  [0:DIV_STAGES];
    logic                r_neg  [0:DIV_STAGES];
    logic                r_dz   [0:DIV_STAGES];
    logic                r_apos [0:DIV_STAGES];

    logic [FX_W-1:0] mag_a;
    logic [FX_W-1:0] mag_b;

    // control shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]   <= i_q;
            r_pay[0] <= i_payload;
            r_sat[0] <= i_sat;
            for (int k = 1; k < LAT; k++) begin
                r_q[k]   <= r_q[k-1];
                r_pay[k] <= r_pay[k-1];
            end
            for (int k = 1; k <= DIV_STAGES; k++) r_sat[k] <= r_sat[k-1];
        end
    end

    // divider entry
    always_comb begin
        mag_a = i_q.m[FX_W-1] ? -i_q.m : i_q.m;
        mag_b = i_q.r[FX_W-1] ? -i_q.r : i_q.r;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0]  <= {mag_a, {FX_FRAC{1'b0}}};
            r_quo[0]  <= '0;
            r_den[0]  <= mag_b;
            r_rem[0]  <= '0;
            r_neg[0]  <= i_q.m[FX_W-1] ^ i_q.r[FX_W-1];
            r_dz[0]   <= (i_q.r == '0);
            r_apos[0] <= !i_q.m[FX_W-1];
        end
    end

    // restoring divide, a few quotient bits per stage
    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        logic [DIV_BITS-1:0] n_num;
        logic [DIV_BITS-1:0] n_quo;
        logic [FX_W-1:0]     n_rem;
        logic [FX_W:0]       tmp;

        always_comb begin
            n_num = r_num[k-1];
            n_quo = r_quo[k-1];
            n_rem = r_rem[k-1];
            tmp   = '0;
            for (int i = 0; i < DIV_STEP; i++) begin
                tmp   = {n_rem, n_num[DIV_BITS-1]};
                n_num = n_num << 1;
                if (tmp >= {1'b0, r_den[k-1]}) begin
                    tmp   = tmp - {1'b0, r_den[k-1]};
                    n_quo = {n_quo[DIV_BITS-2:0], 1'b1};
                end else begin
                    n_quo = {n_quo[DIV_BITS-2:0], 1'b0};
                end
                n_rem = tmp[FX_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= n_num;
                r_quo[k]  <= n_quo;
                r_rem[k]  <= n_rem;
                r_den[k]  <= r_den[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_dz[k]   <= r_dz[k-1];
                r_apos[k] <= r_apos[k-1];
            end
        end
    end

    // quotient sign and saturation
    t_fx  n_vel;
    logic n_vsat;
    t_fx  r_vel_d;
    logic r_sat_d;

    always_comb begin
        n_vel  = r_quo[DIV_STAGES][FX_W-1:0];
        n_vsat = 1'b0;
        if (r_dz[DIV_STAGES]) begin
            n_vel  = r_apos[DIV_STAGES] ? FX_MAX : FX_MIN;
            n_vsat = 1'b1;
        end else if (r_neg[DIV_STAGES]) begin
            if (r_quo[DIV_STAGES] > 48'd2147483648) begin
                n_vel  = FX_MIN;
                n_vsat = 1'b1;
            end else begin
                n_vel = -r_quo[DIV_STAGES][FX_W-1:0];
            end
        end else if (r_quo[DIV_STAGES] > 48'd2147483647) begin
            n_vel  = FX_MAX;
            n_vsat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vel_d <= n_vel;
            r_sat_d <= r_sat[DIV_STAGES] | n_vsat;
        end
    end

    // flux stage a: m*v, g*e, (g-1)*e
    localparam int SA = DIV_STAGES + 1;
    t_res m_mv, m_ge, m_gme;
    t_fx  r_vel_a, r_mv_a, r_ge_a, r_gme_a;
    logic r_sat_a;

    always_comb begin
        m_mv  = fx_mul(r_q[SA].m, r_vel_d);
        m_ge  = fx_mul(i_coef.g, r_q[SA].e);
        m_gme = fx_mul(i_coef.gm1, r_q[SA].e);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vel_a <= r_vel_d;
            r_mv_a  <= m_mv.v;
            r_ge_a  <= m_ge.v;
            r_gme_a <= m_gme.v;
            r_sat_a <= r_sat_d | m_mv.s | m_ge.s | m_gme.s;
        end
    end

    // flux stage b: coefficient products of m^2/r
    t_res m_c3, m_c1;
    t_fx  r_vel_b, r_ge_b, r_gme_b, r_c3_b, r_c1_b;
    logic r_sat_b;

    always_comb begin
        m_c3 = fx_mul(i_coef.c3, r_mv_a);
        m_c1 = fx_mul(i_coef.c1, r_mv_a);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vel_b <= r_vel_a;
            r_ge_b  <= r_ge_a;
            r_gme_b <= r_gme_a;
            r_c3_b  <= m_c3.v;
            r_c1_b  <= m_c1.v;
            r_sat_b <= r_sat_a | m_c3.s | m_c1.s;
        end
    end

    // flux stage c: momentum flux and energy term
    t_res s_f1, s_t;
    t_fx  r_vel_c, r_f1_c, r_t_c;
    logic r_sat_c;

    always_comb begin
        s_f1 = fx_add(r_gme_b, r_c3_b);
        s_t  = fx_sub(r_ge_b, r_c1_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vel_c <= r_vel_b;
            r_f1_c  <= s_f1.v;
            r_t_c   <= s_t.v;
            r_sat_c <= r_sat_b | s_f1.s | s_t.s;
        end
    end

    // flux stage d: energy flux
    t_res m_f2;
    t_fx  r_f1_o, r_f2_o;
    logic r_sat_o;

    always_comb begin
        m_f2 = fx_mul(r_t_c, r_vel_c);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1_o  <= r_f1_c;
            r_f2_o  <= m_f2.v;
            r_sat_o <= r_sat_c | m_f2.s;
        end
    end

    always_comb begin
        o_valid   = r_vld[LAT-1];
        o_q       = r_q[LAT-1];
        o_payload = r_pay[LAT-1];
        o_sat     = r_sat_o;
        o_flux.r  = r_q[LAT-1].m;
        o_flux.m  = r_f1_o;
        o_flux.e  = r_f2_o;
    end

endmodule

// File: sv/force_flux_euler_1d.sv
// FORCE interface flux of the 1D Euler equations, signed Q15.16 throughout.
// Input channel: i_valid / o_stall carry one word with the left and right
// cell states; a word is taken at a clock edge with i_valid high and o_stall
// low. Output channel: o_valid / i_stall carry the three interface fluxes
// and a saturation flag for that same word.
// Throughput: one word per cycle while the pipeline is not held by a stall;
// every stage is a register stage and the three velocity quotients come from
// pipelined restoring dividers with four quotient bits per stage, so no unit
// is reused across cycles.
// Stall: the whole pipeline holds while the output register is full and
// i_stall is high; o_stall is raised in exactly those cycles, nothing is
// dropped or repeated.
// Configuration (gamma, dt/dx, dx/dt) is written through i_cfg_we with the
// pipeline empty. Reset clears all valid bits and loads the default
// registers: gamma 1.4, dt/dx 0.5, dx/dt 2.0.
module force_flux_euler_1d
    import fff_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [RATIO_W-1:0]   i_left_density,
    input  logic signed [31:0]   i_left_momentum,
    input  logic signed [31:0]   i_left_energy,
    input  logic [RATIO_W-1:0]   i_right_density,
    input  logic signed [31:0]   i_right_momentum,
    input  logic signed [31:0]   i_right_energy,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_mass_flux,
    output logic signed [31:0]   o_momentum_flux,
    output logic signed [31:0]   o_energy_flux,
    output logic                 o_saturated,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [RATIO_W-1:0]   i_cfg_data
);

    logic en;

    logic [GAMMA_W-1:0] r_heat_ratio;
    logic [RATIO_W-1:0] r_dt_over_dx;
    logic [RATIO_W-1:0] r_dx_over_dt;

    t_coef coef;
    t_fx   hdt;
    t_fx   qdx;
    logic [FX_W-1:0] hdt_w;
    logic [FX_W-1:0] qdx_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_ratio <= HEAT_RATIO_RST;
            r_dt_over_dx <= DT_OVER_DX_RST;
            r_dx_over_dt <= DX_OVER_DT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HEAT_RATIO: r_heat_ratio <= i_cfg_data[GAMMA_W-1:0];
                CFG_DT_OVER_DX: r_dt_over_dx <= i_cfg_data;
                CFG_DX_OVER_DT: r_dx_over_dt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        coef  = make_coef(r_heat_ratio);
        hdt_w = ({1'b0, r_dt_over_dx} + 32'd1) >> 1;
        qdx_w = ({1'b0, r_dx_over_dt} + 32'd2) >> 2;
        hdt   = $signed(hdt_w);
        qdx   = $signed(qdx_w);
    end

    logic r_out_vld;

    assign en      = !r_out_vld || !i_stall;
    assign o_stall = !en;

    // input register
    logic  r_in_vld;
    t_cons r_ql, r_qr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ql.r <= $signed({1'b0, i_left_density});
            r_ql.m <= i_left_momentum;
            r_ql.e <= i_left_energy;
            r_qr.r <= $signed({1'b0, i_right_density});
            r_qr.m <= i_right_momentum;
            r_qr.e <= i_right_energy;
        end
    end

    // cell fluxes
    logic  l_vld, l_sat, rt_sat;
    t_cons l_q, l_f, rt_q, rt_f;

    fff_euler #(.PW(1)) u_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_in_vld),
        .i_q       (r_ql),
        .i_sat     (1'b0),
        .i_payload (1'b0),
        .i_coef    (coef),
        .o_valid   (l_vld),
        .o_q       (l_q),
        .o_flux    (l_f),
        .o_sat     (l_sat),
        .o_payload ()
    );

    fff_euler #(.PW(1)) u_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_in_vld),
        .i_q       (r_qr),
        .i_sat     (1'b0),
        .i_payload (1'b0),
        .i_coef    (coef),
        .o_valid   (),
        .o_q       (rt_q),
        .o_flux    (rt_f),
        .o_sat     (rt_sat),
        .o_payload ()
    );

    // richtmyer state, stage e: flux difference and state average
    t_res  d_r, d_m, d_e;
    logic  r_e_vld, r_e_sat;
    t_cons r_e_d, r_e_avg, r_e_ql, r_e_qr, r_e_fl, r_e_fr;

    always_comb begin
        d_r = fx_sub(l_f.r, rt_f.r);
        d_m = fx_sub(l_f.m, rt_f.m);
        d_e = fx_sub(l_f.e, rt_f.e);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_d.r   <= d_r.v;
            r_e_d.m   <= d_m.v;
            r_e_d.e   <= d_e.v;
            r_e_avg.r <= fx_avg(l_q.r, rt_q.r);
            r_e_avg.m <= fx_avg(l_q.m, rt_q.m);
            r_e_avg.e <= fx_avg(l_q.e, rt_q.e);
            r_e_sat   <= l_sat | rt_sat | d_r.s | d_m.s | d_e.s;
            r_e_ql    <= l_q;
            r_e_qr    <= rt_q;
            r_e_fl    <= l_f;
            r_e_fr    <= rt_f;
        end
    end

    // stage f: scale by dt/dx / 2
    t_res  p_r, p_m, p_e;
    logic  r_f_vld, r_f_sat;
    t_cons r_f_p, r_f_avg, r_f_ql, r_f_qr, r_f_fl, r_f_fr;

    always_comb begin
        p_r = fx_mul(hdt, r_e_d.r);
        p_m = fx_mul(hdt, r_e_d.m);
        p_e = fx_mul(hdt, r_e_d.e);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_p.r <= p_r.v;
            r_f_p.m <= p_m.v;
            r_f_p.e <= p_e.v;
            r_f_sat <= r_e_sat | p_r.s | p_m.s | p_e.s;
            r_f_avg <= r_e_avg;
            r_f_ql  <= r_e_ql;
            r_f_qr  <= r_e_qr;
            r_f_fl  <= r_e_fl;
            r_f_fr  <= r_e_fr;
        end
    end

    // stage g: richtmyer state
    t_res  a_r, a_m, a_e;
    logic  r_g_vld, r_g_sat;
    t_cons r_g_q0, r_g_ql, r_g_qr, r_g_fl, r_g_fr;

    always_comb begin
        a_r = fx_add(r_f_avg.r, r_f_p.r);
        a_m = fx_add(r_f_avg.m, r_f_p.m);
        a_e = fx_add(r_f_avg.e, r_f_p.e);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_q0.r <= a_r.v;
            r_g_q0.m <= a_m.v;
            r_g_q0.e <= a_e.v;
            r_g_sat  <= r_f_sat | a_r.s | a_m.s | a_e.s;
            r_g_ql   <= r_f_ql;
            r_g_qr   <= r_f_qr;
            r_g_fl   <= r_f_fl;
            r_g_fr   <= r_f_fr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= l_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
        end
    end

    // flux of the richtmyer state
    localparam int CW = $bits(t_cons);
    localparam int PW0 = 4 * CW;

    logic           z_vld, z_sat;
    t_cons          z_f0;
    logic [PW0-1:0] z_pay;
    t_cons          z_ql, z_qr, z_fl, z_fr;

    fff_euler #(.PW(PW0)) u_half (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_g_vld),
        .i_q       (r_g_q0),
        .i_sat     (r_g_sat),
        .i_payload ({r_g_ql, r_g_qr, r_g_fl, r_g_fr}),
        .i_coef    (coef),
        .o_valid   (z_vld),
        .o_q       (),
        .o_flux    (z_f0),
        .o_sat     (z_sat),
        .o_payload (z_pay)
    );

    assign {z_ql, z_qr, z_fl, z_fr} = z_pay;

    // stage h: central flux average and state difference
    t_res  q_r, q_m, q_e;
    logic  r_h_vld, r_h_sat;
    t_cons r_h_cin, r_h_dq, r_h_f0;

    always_comb begin
        q_r = fx_sub(z_ql.r, z_qr.r);
        q_m = fx_sub(z_ql.m, z_qr.m);
        q_e = fx_sub(z_ql.e, z_qr.e);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_cin.r <= fx_avg(z_fl.r, z_fr.r);
            r_h_cin.m <= fx_avg(z_fl.m, z_fr.m);
            r_h_cin.e <= fx_avg(z_fl.e, z_fr.e);
            r_h_dq.r  <= q_r.v;
            r_h_dq.m  <= q_m.v;
            r_h_dq.e  <= q_e.v;
            r_h_f0    <= z_f0;
            r_h_sat   <= z_sat | q_r.s | q_m.s | q_e.s;
        end
    end

    // stage i: centre term and diffusion term
    t_res  w_r, w_m, w_e;
    logic  r_i_vld, r_i_sat;
    t_cons r_i_ctr, r_i_dif;

    always_comb begin
        w_r = fx_mul(qdx, r_h_dq.r);
        w_m = fx_mul(qdx, r_h_dq.m);
        w_e = fx_mul(qdx, r_h_dq.e);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_ctr.r <= fx_avg(r_h_f0.r, r_h_cin.r);
            r_i_ctr.m <= fx_avg(r_h_f0.m, r_h_cin.m);
            r_i_ctr.e <= fx_avg(r_h_f0.e, r_h_cin.e);
            r_i_dif.r <= w_r.v;
            r_i_dif.m <= w_m.v;
            r_i_dif.e <= w_e.v;
            r_i_sat   <= r_h_sat | w_r.s | w_m.s | w_e.s;
        end
    end

    // output register
    t_res o_r, o_m, o_e;
    t_fx  r_mass, r_mom, r_energy;
    logic r_sat_out;

    always_comb begin
        o_r = fx_add(r_i_ctr.r, r_i_dif.r);
        o_m = fx_add(r_i_ctr.m, r_i_dif.m);
        o_e = fx_add(r_i_ctr.e, r_i_dif.e);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mass    <= o_r.v;
            r_mom     <= o_m.v;
            r_energy  <= o_e.v;
            r_sat_out <= r_i_sat | o_r.s | o_m.s | o_e.s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld   <= 1'b0;
            r_i_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_h_vld   <= z_vld;
            r_i_vld   <= r_h_vld;
            r_out_vld <= r_i_vld;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_mass_flux     = r_mass;
    assign o_momentum_flux = r_mom;
    assign o_energy_flux   = r_energy;
    assign o_saturated     = r_sat_out;

endmodule

// File: verif/force_flux_euler_1d_test.sv
`timescale 1ns / 100ps

module force_flux_euler_1d_test;
    import fff_pkg::*;

    localparam int LATENCY = 42;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM = 500;

    typedef struct {
        logic [30:0] rl;
        logic [31:0] ml;
        logic [31:0] el;
        logic [30:0] rr;
        logic [31:0] mr;
        logic [31:0] er;
    } t_word;

    typedef struct packed {
        logic [31:0] mass;
        logic [31:0] mom;
        logic [31:0] energy;
        logic        sat;
    } t_flux;

    typedef struct {
        t_word w;
        logic  known;
        t_flux f;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [RATIO_W-1:0] i_left_density;
    logic signed [31:0] i_left_momentum;
    logic signed [31:0] i_left_energy;
    logic [RATIO_W-1:0] i_right_density;
    logic signed [31:0] i_right_momentum;
    logic signed [31:0] i_right_energy;
    logic              o_valid;
    logic              i_stall;
    logic signed [31:0] o_mass_flux;
    logic signed [31:0] o_momentum_flux;
    logic signed [31:0] o_energy_flux;
    logic              o_saturated;
    logic              i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [RATIO_W-1:0] i_cfg_data;

    force_flux_euler_1d dut (.*);

    longint gamma_q, dtdx_q, dxdt_q;
    bit     sat_flag;
    t_flux  flux_queue[$];
    int     mismatches;
    int     idle_cycles;
    bit     stall_pressure;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) begin
            sat_flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat_flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint rnd_shift(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return sat32(rnd_shift(a * b, 16));
    endfunction

    function automatic longint qdiv(longint a, longint b);
        if (b == 0) begin
            sat_flag = 1'b1;
            return (a >= 0) ? 64'sd2147483647 : -64'sd2147483648;
        end
        return sat32((a * 65536) / b);
    endfunction

    task automatic cell_flux(input longint q[3], output longint f[3]);
        longint g, gm1, c3, c1, v, mv;
        g   = gamma_q;
        gm1 = g - 65536;
        c3  = rnd_shift(196608 - g, 1);
        c1  = rnd_shift(gm1, 1);
        v   = qdiv(q[1], q[0]);
        mv  = qmul(q[1], v);
        f[0] = q[1];
        f[1] = sat32(qmul(gm1, q[2]) + qmul(c3, mv));
        f[2] = qmul(sat32(qmul(g, q[2]) - qmul(c1, mv)), v);
    endtask

    task automatic force_flux(input t_word w, output t_flux o);
        longint ql[3], qr[3], fl[3], fr[3], q0[3], f0[3], res[3];
        longint hdt, qdx, mid;
        sat_flag = 1'b0;
        ql[0] = longint'(w.rl);
        ql[1] = longint'($signed(w.ml));
        ql[2] = longint'($signed(w.el));
        qr[0] = longint'(w.rr);
        qr[1] = longint'($signed(w.mr));
        qr[2] = longint'($signed(w.er));
        hdt = rnd_shift(dtdx_q, 1);
        qdx = rnd_shift(dxdt_q, 2);
        cell_flux(ql, fl);
        cell_flux(qr, fr);
        for (int j = 0; j < 3; j++)
            q0[j] = sat32(rnd_shift(ql[j] + qr[j], 1) + qmul(hdt, sat32(fl[j] - fr[j])));
        cell_flux(q0, f0);
        for (int j = 0; j < 3; j++) begin
            mid = rnd_shift(f0[j] + rnd_shift(fl[j] + fr[j], 1), 1);
            res[j] = sat32(mid + qmul(qdx, sat32(ql[j] - qr[j])));
        end
        o.mass   = res[0][31:0];
        o.mom    = res[1][31:0];
        o.energy = res[2][31:0];
        o.sat    = sat_flag;
    endtask

    // no gap half of the time, otherwise mostly short gaps and a few long ones
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic logic [30:0] rand_density();
        case ($urandom_range(3))
            0: return 31'($urandom_range(1 << 20, 1 << 14));
            1: return 31'($urandom_range(4 << 16, 1 << 16));
            2: return 31'($urandom());
            default: return 31'($urandom_range(3, 0));
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return 32'($signed($urandom_range(1 << 20, 0)) - (1 << 19));
            1: return 32'($signed($urandom_range(8 << 16, 0)) - (4 << 16));
            default: return $urandom();
        endcase
    endfunction

    task automatic write_cfg(t_cfg_idx idx, logic [RATIO_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_HEAT_RATIO: gamma_q = longint'(val[GAMMA_W-1:0]);
            CFG_DT_OVER_DX: dtdx_q  = longint'(val);
            CFG_DX_OVER_DT: dxdt_q  = longint'(val);
            default: ;
        endcase
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (flux_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_word(t_word w, logic known, t_flux given);
        int    gap;
        t_flux f;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        force_flux(w, f);
        if (known && f !== given)
            $display("table row disagrees with predictor: %h %h", given, f);
        if (known) f = given;
        i_valid          <= 1'b1;
        i_left_density   <= w.rl;
        i_left_momentum  <= w.ml;
        i_left_energy    <= w.el;
        i_right_density  <= w.rr;
        i_right_momentum <= w.mr;
        i_right_energy   <= w.er;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        flux_queue.push_back(f);
    endtask

    t_row directed_words[$];

    task automatic add_row(logic [30:0] rl, logic [31:0] ml, logic [31:0] el,
                           logic [30:0] rr, logic [31:0] mr, logic [31:0] er);
        t_row r;
        r.w = '{rl, ml, el, rr, mr, er};
        r.known = 1'b0;
        r.f = '{32'h0, 32'h0, 32'h0, 1'b0};
        directed_words.push_back(r);
    endtask

    task automatic build_table();
        t_row r;
        // gas at rest with no energy, equal sides: all fluxes zero
        r.w = '{31'h10000, 32'h0, 32'h0, 31'h10000, 32'h0, 32'h0};
        r.known = 1'b1;
        r.f = '{32'h0, 32'h0, 32'h0, 1'b0};
        directed_words.push_back(r);
        add_row(31'h10000, 32'h0, 32'h28000, 31'h10000, 32'h0, 32'h28000);
        add_row(31'h10000, 32'h0, 32'h28000, 31'h2000, 32'h0, 32'h4000);
        add_row(31'h10000, 32'h10000, 32'h30000, 31'h10000, 32'hffff0000, 32'h30000);
        add_row(31'h1, 32'h7fffffff, 32'h7fffffff, 31'h1, 32'h80000000, 32'h80000000);
        add_row(31'h7fffffff, 32'h7fffffff, 32'h80000000,
                31'h7fffffff, 32'h80000000, 32'h7fffffff);
        add_row(31'h7fffffff, 32'h0, 32'h0, 31'h1, 32'h0, 32'h0);
        add_row(31'h0, 32'h10000, 32'h10000, 31'h10000, 32'h0, 32'h10000);
        add_row(31'h0, 32'h0, 32'h0, 31'h0, 32'h0, 32'h0);
        add_row(31'h0, 32'hffff0000, 32'h0, 31'h0, 32'h10000, 32'h0);
        // momentum jumps between the sides, then irregular bit patterns
        add_row(31'h10000, 32'h20000, 32'h40000, 31'h10000, 32'h0, 32'h10000);
        add_row(31'h800, 32'h40000, 32'h80000, 31'h800, 32'hfffc0000, 32'h80000);
        add_row(31'h5555, 32'h12345, 32'hffffabcd, 31'h2aaaa, 32'hfedcb, 32'h54321);
        add_row(31'h55555555, 32'haaaaaaaa, 32'h55555555,
                31'h2aaaaaaa, 32'h55555555, 32'haaaaaaaa);
    endtask

    task automatic run_directed();
        foreach (directed_words[k])
            send_word(directed_words[k].w, directed_words[k].known, directed_words[k].f);
    endtask

    task automatic run_random(int n);
        t_word w;
        t_flux none;
        none = '{32'h0, 32'h0, 32'h0, 1'b0};
        for (int k = 0; k < n; k++) begin
            w.rl = rand_density();
            w.ml = rand_value();
            w.el = rand_value();
            w.rr = ($urandom_range(3) == 0) ? w.rl : rand_density();
            w.mr = rand_value();
            w.er = rand_value();
            send_word(w, 1'b0, none);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_HEAT_RATIO;
        i_cfg_data = '0;
        i_left_density = '0;
        i_left_momentum = '0;
        i_left_energy = '0;
        i_right_density = '0;
        i_right_momentum = '0;
        i_right_energy = '0;
        mismatches = 0;
        gamma_q = longint'(HEAT_RATIO_RST);
        dtdx_q  = longint'(DT_OVER_DX_RST);
        dxdt_q  = longint'(DX_OVER_DT_RST);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_table();
        run_directed();
        run_random(N_RANDOM / 5);
        drain();

        write_cfg(CFG_HEAT_RATIO, 31'd65537);
        write_cfg(CFG_DT_OVER_DX, 31'd0);
        write_cfg(CFG_DX_OVER_DT, 31'h7fffffff);
        i_cfg_we <= 1'b0;
        run_directed();
        run_random(N_RANDOM / 5);
        drain();

        write_cfg(CFG_HEAT_RATIO, 31'd196607);
        write_cfg(CFG_DT_OVER_DX, 31'h7fffffff);
        write_cfg(CFG_DX_OVER_DT, 31'd0);
        i_cfg_we <= 1'b0;
        run_random(N_RANDOM / 5);
        drain();

        write_cfg(CFG_HEAT_RATIO, 31'h3ffff);
        write_cfg(CFG_DT_OVER_DX, 31'($urandom_range(1 << 17)));
        write_cfg(CFG_DX_OVER_DT, 31'($urandom_range(1 << 18)));
        i_cfg_we <= 1'b0;
        run_random(N_RANDOM / 5);
        drain();

        write_cfg(CFG_HEAT_RATIO, 31'($urandom_range(196607, 65537)));
        write_cfg(CFG_DT_OVER_DX, 31'h0aaaaaaa);
        write_cfg(CFG_DX_OVER_DT, 31'h55555555);
        i_cfg_we <= 1'b0;
        run_random(N_RANDOM / 5);
        drain();

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // output side stall pattern
    initial begin
        forever begin
            @(posedge i_clk);
            repeat (gap_len()) @(posedge i_clk);
            i_stall <= 1'b1;
            repeat (1 + gap_len()) @(posedge i_clk);
            i_stall <= 1'b0;
            repeat ($urandom_range(60) == 0 ? 80 : 0) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_flux exp_f;
        if (i_rst_n && o_valid && !i_stall) begin
            if (flux_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected flux word");
            end else begin
                exp_f = flux_queue.pop_front();
                if (o_mass_flux !== exp_f.mass || o_momentum_flux !== exp_f.mom ||
                    o_energy_flux !== exp_f.energy || o_saturated !== exp_f.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("flux mismatch exp %h %h %h %b got %h %h %h %b",
                                 exp_f.mass, exp_f.mom, exp_f.energy, exp_f.sat,
                                 o_mass_flux, o_momentum_flux, o_energy_flux,
                                 o_saturated);
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
